// ===== rtl/bphs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bphs_pkg
// Types and constants of the bounded probe hash store.
// ----------------------------------------------------------------------------
package bphs_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int PROBE_LIMIT_DEF = 128;

  localparam int CFG_W   = 13;
  localparam int COUNT_W = 13;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  localparam logic [CFG_W-1:0]   TABLE_LENGTH_RESET = 13'd4096;
  localparam logic [COUNT_W-1:0] COUNT_MAX          = 13'd8191;
  localparam logic [VAL_W-1:0]   Q_MAX              = 32'h7FFF_FFFF;

  // restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef enum logic [1:0] {
    ST_UPDATED     = 2'd0,
    ST_INSERTED    = 2'd1,
    ST_EVICT_MIN   = 2'd2,
    ST_EVICT_START = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PROBE,
    S_WRITE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key_high;
    logic [KEY_W-1:0]        key_low;
    logic signed [VAL_W-1:0] value;
  } slot_t;

endpackage

// ===== rtl/bounded_probe_hash_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_probe_hash_store
// Hash-keyed statistics table with bounded linear probing and min eviction.
// ----------------------------------------------------------------------------
// One item is handled at a time. After the input transfer the start slot is
// found by a restoring divider (hash_low modulo the table length), one bit a
// cycle. Then the slot memory is walked through its single read port, one slot
// read a cycle, with the compare in the cycle after the read: min(PROBE_LIMIT,
// length - start) slots, then the last read is compared and the walk closes
// (a hit ends the walk at its compare). A store then writes its slot in
// S_WRITE, S_RESP loads the output register once it is free, and S_IDLE takes
// the next transfer. After reset a clearing pass writes zero to every slot,
// during which no item is accepted; configuration writes are taken at any
// time.
// ----------------------------------------------------------------------------
module bounded_probe_hash_store #(
  parameter int TABLE_DEPTH = bphs_pkg::TABLE_DEPTH_DEF,
  parameter int PROBE_LIMIT = bphs_pkg::PROBE_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration: table_length
  input  logic                       cfg_we,
  input  logic [bphs_pkg::CFG_W-1:0] cfg_wdata,
  // input channel
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [95:0]                in_tdata,   // hash_low, hash_high, new_value
  input  logic                       in_tuser,   // operation
  // result channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [47:0]                out_tdata   // found, read_value, store_status,
                                                 // used_count
);
  import bphs_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PCNT_W = $clog2(PROBE_LIMIT + 1);

  // slot memory
  slot_t mem [TABLE_DEPTH];
  slot_t rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  slot_t             mem_wdata;
  logic [ADDR_W-1:0] rd_addr;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   cfg_len_r;
  logic [COUNT_W-1:0] filled_r, filled_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [47:0]        out_tdata_r, out_tdata_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic               rd_vld_r, rd_vld_nxt;

  logic              op_r, op_nxt;
  logic [KEY_W-1:0]  hl_r, hl_nxt;
  logic [KEY_W-1:0]  hh_r, hh_nxt;
  logic [VAL_W-1:0]  nv_r, nv_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [31:0]       div_r, div_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]  iss_addr_r, iss_addr_nxt;
  logic [PCNT_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [ADDR_W-1:0] rd_slot_r, rd_slot_nxt;
  logic              have_min_r, have_min_nxt;
  logic [VAL_W-1:0]  min_val_r, min_val_nxt;
  logic [ADDR_W-1:0] min_slot_r, min_slot_nxt;
  logic [ADDR_W-1:0] wr_slot_r, wr_slot_nxt;
  logic              found_r, found_nxt;
  logic [VAL_W-1:0]  rv_r, rv_nxt;
  status_t           status_r, status_nxt;

  // effective length and divider step
  logic [31:0]      cfg_ext;
  logic [31:0]      len_sel;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   rem_sub;
  logic [LEN_W-1:0] rem_new;

  // probe compare
  logic key_hit, slot_empty, val_lower, stop_hit, more, issue, walk_end;

  assign cfg_ext = {{(32-CFG_W){1'b0}}, cfg_len_r};
  assign len_sel = (cfg_len_r == '0) ? 32'd1 :
                   (cfg_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cfg_ext;

  assign rem_sh  = {rem_r, div_r[31]};
  assign rem_sub = (rem_sh >= {1'b0, len_r}) ? (rem_sh - {1'b0, len_r}) : rem_sh;
  assign rem_new = rem_sub[LEN_W-1:0];

  assign key_hit    = (rd_data_r.key_low == hl_r) && (rd_data_r.key_high == hh_r);
  assign slot_empty = (rd_data_r.key_low == '0) && (rd_data_r.key_high == '0);
  assign val_lower  = $signed(rd_data_r.value) < $signed(min_val_r);
  assign stop_hit   = rd_vld_r && (key_hit || ((op_r == OP_STORE) && slot_empty));
  assign more       = (iss_cnt_r < PCNT_W'(PROBE_LIMIT)) && (iss_addr_r < len_r);
  assign issue      = (state_r == S_PROBE) && !stop_hit && more;
  assign walk_end   = !rd_vld_r && !more;

  assign rd_addr    = iss_addr_r[ADDR_W-1:0];
  assign mem_we     = (state_r == S_CLEAR) || (state_r == S_WRITE);
  assign mem_waddr  = (state_r == S_CLEAR) ? clr_addr_r : wr_slot_r;
  assign mem_wdata  = (state_r == S_CLEAR) ? '0 : slot_t'{hh_r, hl_r, nv_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    filled_nxt     = filled_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    clr_addr_nxt   = clr_addr_r;
    rd_vld_nxt     = issue;
    op_nxt         = op_r;
    hl_nxt         = hl_r;
    hh_nxt         = hh_r;
    nv_nxt         = nv_r;
    len_nxt        = len_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    bit_cnt_nxt    = bit_cnt_r;
    start_nxt      = start_r;
    iss_addr_nxt   = iss_addr_r;
    iss_cnt_nxt    = iss_cnt_r;
    rd_slot_nxt    = rd_slot_r;
    have_min_nxt   = have_min_r;
    min_val_nxt    = min_val_r;
    min_slot_nxt   = min_slot_r;
    wr_slot_nxt    = wr_slot_r;
    found_nxt      = found_r;
    rv_nxt         = rv_r;
    status_nxt     = status_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          hl_nxt      = in_tdata[31:0];
          hh_nxt      = in_tdata[63:32];
          nv_nxt      = in_tdata[95:64];
          len_nxt     = len_sel[LEN_W-1:0];
          div_nxt     = in_tdata[31:0];
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt     = rem_new;
        div_nxt     = {div_r[30:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + DIV_CNT_W'(1);
        if (bit_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          start_nxt    = rem_new[ADDR_W-1:0];
          iss_addr_nxt = rem_new;
          iss_cnt_nxt  = '0;
          have_min_nxt = 1'b0;
          min_val_nxt  = Q_MAX;
          state_nxt    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (issue) begin
          rd_slot_nxt  = iss_addr_r[ADDR_W-1:0];
          iss_addr_nxt = iss_addr_r + LEN_W'(1);
          iss_cnt_nxt  = iss_cnt_r + PCNT_W'(1);
        end
        if (stop_hit) begin
          wr_slot_nxt = rd_slot_r;
          rv_nxt      = '0;
          if (key_hit) begin
            found_nxt  = 1'b1;
            status_nxt = ST_UPDATED;
            if (op_r == OP_LOOKUP) begin
              rv_nxt    = rd_data_r.value;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_WRITE;
            end
          end else begin
            // empty slot on a store: claim it
            found_nxt  = 1'b0;
            status_nxt = ST_INSERTED;
            if (filled_r < COUNT_MAX) begin
              filled_nxt = filled_r + COUNT_W'(1);
            end
            state_nxt = S_WRITE;
          end
        end else if (rd_vld_r) begin
          if (val_lower) begin
            have_min_nxt = 1'b1;
            min_val_nxt  = rd_data_r.value;
            min_slot_nxt = rd_slot_r;
          end
        end else if (walk_end) begin
          found_nxt  = 1'b0;
          rv_nxt     = '0;
          status_nxt = ST_UPDATED;
          if (op_r == OP_LOOKUP) begin
            state_nxt = S_RESP;
          end else begin
            wr_slot_nxt = have_min_r ? min_slot_r : start_r;
            status_nxt  = have_min_r ? ST_EVICT_MIN : ST_EVICT_START;
            state_nxt   = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {filled_r, status_r, rv_r, found_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cfg_len_r    <= TABLE_LENGTH_RESET;
      filled_r     <= '0;
      out_tvalid_r <= 1'b0;
      clr_addr_r   <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      filled_r     <= filled_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      clr_addr_r   <= clr_addr_nxt;
      rd_vld_r     <= rd_vld_nxt;
      if (cfg_we) begin
        cfg_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    op_r        <= op_nxt;
    hl_r        <= hl_nxt;
    hh_r        <= hh_nxt;
    nv_r        <= nv_nxt;
    len_r       <= len_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    start_r     <= start_nxt;
    iss_addr_r  <= iss_addr_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    rd_slot_r   <= rd_slot_nxt;
    have_min_r  <= have_min_nxt;
    min_val_r   <= min_val_nxt;
    min_slot_r  <= min_slot_nxt;
    wr_slot_r   <= wr_slot_nxt;
    found_r     <= found_nxt;
    rv_r        <= rv_nxt;
    status_r    <= status_nxt;
  end

  // start slot from the divider lies inside the table
  a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && $past(state_r) == S_DIV) |-> ({1'b0, start_r} < (LEN_W+1)'(len_r)))
    else $error("start slot beyond table length");

  // no slot read in flight once a new item can be taken
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !rd_vld_r)
    else $error("probe read pending while ready");

  // fill count only steps up by one
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (filled_r == $past(filled_r) ||
                      filled_r == $past(filled_r) + COUNT_W'(1)))
    else $error("used count jumped");

  // a key match reports an update
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && found_r) |-> (status_r == ST_UPDATED))
    else $error("match reported with insert or evict status");

endmodule

// ===== tb/bounded_probe_hash_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_probe_hash_store_tb
// Self-checking bench for the bounded probe hash store.
// ----------------------------------------------------------------------------
// A short table of directed transfers covers the field extremes, the zero key
// pair, the one-slot window at the table end and the clamped table lengths.
// Random phases follow at several table lengths, with key pools that crowd
// one region so that inserts, updates and both kinds of eviction occur, the
// probe window runs out, and the receiver stalls long enough to back up the
// input. Every result is checked field by field, against the values of its
// directed row where the row gives them, else against a table model kept here.
// ----------------------------------------------------------------------------
module bounded_probe_hash_store_tb;
  import bphs_pkg::*;

  localparam int TABLE_DEPTH    = TABLE_DEPTH_DEF;
  localparam int PROBE_LIMIT    = PROBE_LIMIT_DEF;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int HOLD_CYCLES    = 500;
  localparam int IDLE_PCT       = 38;

  // where a phase's key pool clusters its start slots
  localparam int ANCHOR_LOW = 0;
  localparam int ANCHOR_END = 1;
  localparam int ANCHOR_ANY = 2;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_value;
    logic [KEY_W-1:0]        hash_high;
    logic [KEY_W-1:0]        hash_low;
  } probe_data_t;

  typedef struct packed {
    logic        op;
    probe_data_t data;
  } probe_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]      used_count;
    status_t                 status;
    logic signed [VAL_W-1:0] read_value;
    logic                    found;
  } probe_result_t;

  typedef struct packed {
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
  } key_pair_t;

  typedef struct {
    logic [CFG_W-1:0] length;
    probe_item_t      item;
    bit               typed;
    probe_result_t    res;
  } directed_row_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [95:0]        in_tdata   = '0;  // hash_low, hash_high, new_value
  logic               in_tuser   = 1'b0; // operation
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [47:0]        out_tdata;         // found, read_value, store_status, used_count

  // table model
  logic [KEY_W-1:0]        slot_lo  [TABLE_DEPTH];
  logic [KEY_W-1:0]        slot_hi  [TABLE_DEPTH];
  logic signed [VAL_W-1:0] slot_val [TABLE_DEPTH];
  logic [COUNT_W-1:0]      model_filled;
  logic [CFG_W-1:0]        model_length;

  probe_result_t awaited_results[$];
  key_pair_t     key_pool[$];
  directed_row_t directed_rows[$];

  bit            use_typed;
  probe_result_t typed_result;
  bit            gaps_on = 1'b1;
  bit            hold_req = 1'b0;
  int            errors = 0;
  int            quiet_cycles = 0;

  bounded_probe_hash_store u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned span_of(input logic [CFG_W-1:0] len);
    if (len == 0) return 1;
    if (len > TABLE_DEPTH) return TABLE_DEPTH;
    return len;
  endfunction

  // walk the probe window once, as the block does, and update the model
  function automatic probe_result_t predict_probe(input probe_item_t it);
    probe_result_t           r;
    int unsigned             span, first, s, lowest_slot, i;
    logic signed [VAL_W-1:0] lowest;
    bit                      have_lowest, done;
    r            = '0;
    span         = span_of(model_length);
    first        = it.data.hash_low % span;
    lowest       = Q_MAX;
    lowest_slot  = first;
    have_lowest  = 1'b0;
    done         = 1'b0;
    for (i = 0; i < PROBE_LIMIT && first + i < span && !done; i++) begin
      s = first + i;
      if (slot_lo[s] == it.data.hash_low && slot_hi[s] == it.data.hash_high) begin
        r.found = 1'b1;
        if (it.op == OP_LOOKUP) begin
          r.read_value = slot_val[s];
        end else begin
          slot_val[s] = it.data.new_value;
          r.status    = ST_UPDATED;
        end
        done = 1'b1;
      end else if (it.op == OP_STORE && slot_lo[s] == 0 && slot_hi[s] == 0) begin
        slot_lo[s]  = it.data.hash_low;
        slot_hi[s]  = it.data.hash_high;
        slot_val[s] = it.data.new_value;
        if (model_filled != COUNT_MAX) model_filled++;
        r.status = ST_INSERTED;
        done     = 1'b1;
      end else if (it.op == OP_STORE && slot_val[s] < lowest) begin
        lowest      = slot_val[s];
        lowest_slot = s;
        have_lowest = 1'b1;
      end
    end
    if (it.op == OP_STORE && !done) begin
      s           = have_lowest ? lowest_slot : first;
      slot_lo[s]  = it.data.hash_low;
      slot_hi[s]  = it.data.hash_high;
      slot_val[s] = it.data.new_value;
      r.status    = have_lowest ? ST_EVICT_MIN : ST_EVICT_START;
    end
    r.used_count = model_filled;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic probe_item_t make_item(input logic op, input logic [31:0] hl,
                                            input logic [31:0] hh, input logic [31:0] nv);
    probe_item_t it;
    it.op             = op;
    it.data.hash_low  = hl;
    it.data.hash_high = hh;
    it.data.new_value = nv;
    return it;
  endfunction

  function automatic directed_row_t dir_row(
    input logic [CFG_W-1:0] len, input logic op, input logic [31:0] hl,
    input logic [31:0] hh, input logic [31:0] nv, input bit typed, input logic fnd,
    input logic [31:0] rv, input status_t st, input logic [COUNT_W-1:0] used);
    directed_row_t d;
    d.length         = len;
    d.item           = make_item(op, hl, hh, nv);
    d.typed          = typed;
    d.res.found      = fnd;
    d.res.read_value = rv;
    d.res.status     = st;
    d.res.used_count = used;
    return d;
  endfunction

  function automatic logic [31:0] rand_q_value();
    case ($urandom_range(0, 9))
      0, 1:    return Q_MAX;
      2:       return 32'h8000_0000;
      3:       return 32'($urandom_range(0, 511)) - 32'd256;
      default: return $urandom;
    endcase
  endfunction

  // model, result check and config tracking, all on the rising edge
  always @(posedge clk) begin : scoreboard
    probe_result_t got, want, calc;
    if (!rst_n) begin
      foreach (slot_lo[k]) begin
        slot_lo[k]  = '0;
        slot_hi[k]  = '0;
        slot_val[k] = '0;
      end
      model_filled = '0;
      model_length = TABLE_LENGTH_RESET;
    end else begin
      if (cfg_we) model_length = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got = probe_result_t'(out_tdata);
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("found", want.found, got.found);
          check_field("read_value", want.read_value, got.read_value);
          check_field("store_status", want.status, got.status);
          check_field("used_count", want.used_count, got.used_count);
        end
      end
      if (in_tvalid && in_tready) begin
        calc = predict_probe(probe_item_t'({in_tuser, in_tdata}));
        awaited_results.push_back(use_typed ? typed_result : calc);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic send_item(input probe_item_t it, input bit typed, input probe_result_t res);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= it.data;
    in_tuser     <= it.op;
    use_typed    = typed;
    typed_result = res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_length(input logic [CFG_W-1:0] len);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] len, input int n_items,
                           input int pool_size, input int store_pct, input int anchor,
                           input bit idle, input bit hold);
    int unsigned span, first, off;
    key_pair_t   key;
    logic        op;
    set_length(len);
    gaps_on = idle;
    span    = span_of(len);
    case (anchor)
      ANCHOR_LOW: first = 0;
      ANCHOR_END: first = (span > 12) ? span - 12 : 0;
      default:    first = $urandom_range(0, span - 1);
    endcase
    // keys whose start slots crowd the anchor and the three slots after it
    key_pool.delete();
    repeat (pool_size) begin
      off = first + $urandom_range(0, 3);
      if (off >= span) off = span - 1;
      key.lo = off + span * $urandom_range(0, (32'hFFFF_FFFF - off) / span);
      key.hi = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
      if ($urandom_range(0, 39) == 0) key = '0;
      key_pool.push_back(key);
    end
    for (int n = 0; n < n_items; n++) begin
      if (hold && n == 5) hold_req = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        key.lo = $urandom;
        key.hi = $urandom;
      end else begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      op = ($urandom_range(0, 99) < store_pct) ? OP_STORE : OP_LOOKUP;
      send_item(make_item(op, key.lo, key.hi, rand_q_value()), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] cur_length;
    cur_length = TABLE_LENGTH_RESET;

    // empty table, default length
    directed_rows.push_back(dir_row(13'd4096, OP_LOOKUP, 32'h0, 32'h0, 32'h0,
                                    1, 1'b1, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd4096, OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                                    1, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd4096, OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Q_MAX,
                                    1, 1'b0, 32'h0, ST_INSERTED, 13'd1));
    directed_rows.push_back(dir_row(13'd4096, OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                                    1, 1'b1, Q_MAX, ST_UPDATED, 13'd1));
    directed_rows.push_back(dir_row(13'd4096, OP_STORE, 32'h1000, 32'h1, 32'h8000_0000,
                                    1, 1'b0, 32'h0, ST_INSERTED, 13'd2));
    directed_rows.push_back(dir_row(13'd4096, OP_LOOKUP, 32'h1000, 32'h1, 32'h0,
                                    1, 1'b1, 32'h8000_0000, ST_UPDATED, 13'd2));
    directed_rows.push_back(dir_row(13'd4096, OP_STORE, 32'h1000, 32'h1, 32'h100,
                                    1, 1'b1, 32'h0, ST_UPDATED, 13'd2));
    // zero key pair lands on an empty slot and leaves it empty
    directed_rows.push_back(dir_row(13'd4096, OP_STORE, 32'h0, 32'h0, 32'h1234,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd4096, OP_LOOKUP, 32'h0, 32'h0, 32'h0,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd4096, OP_STORE, 32'h2000, 32'h5, 32'hFFFF_FFFF,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    // last slot: window of one, holding the largest value, then a lower one
    directed_rows.push_back(dir_row(13'd4096, OP_STORE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FF00,
                                    1, 1'b0, 32'h0, ST_EVICT_START, 13'd3));
    directed_rows.push_back(dir_row(13'd4096, OP_STORE, 32'h0FFF, 32'h7, 32'h5,
                                    1, 1'b0, 32'h0, ST_EVICT_MIN, 13'd3));
    directed_rows.push_back(dir_row(13'd4096, OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    // length zero acts as one
    directed_rows.push_back(dir_row(13'd0, OP_STORE, 32'h12345, 32'h9, Q_MAX,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd0, OP_LOOKUP, 32'hABCD_EF01, 32'h9, 32'h0,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd0, OP_STORE, 32'h0, 32'h0, Q_MAX,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd0, OP_STORE, 32'h1357_9BDF, 32'h2468_ACE0, 32'h42,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    // length above the depth acts as the depth, then length one
    directed_rows.push_back(dir_row(13'd8191, OP_LOOKUP, 32'h0FFF, 32'h7, 32'h0,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd8191, OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Q_MAX,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd1, OP_LOOKUP, 32'h1357_9BDF, 32'h2468_ACE0, 32'h0,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));
    directed_rows.push_back(dir_row(13'd1, OP_STORE, 32'h8000_0000, 32'h1, 32'h8000_0000,
                                    0, 1'b0, 32'h0, ST_UPDATED, 13'd0));

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].length != cur_length) begin
        set_length(directed_rows[k].length);
        cur_length = directed_rows[k].length;
      end
      send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].res);
    end

    // first phase: more stores than the probe window holds, most starting near slot 0
    run_phase(13'd4096, 220, 170, 75, ANCHOR_LOW, 1'b1, 1'b0);
    run_phase(13'd300,   80,  40, 60, ANCHOR_END, 1'b1, 1'b1);
    run_phase(13'd7,     80,  20, 60, ANCHOR_ANY, 1'b0, 1'b0);
    run_phase(13'd8191,  60,  60, 60, ANCHOR_ANY, 1'b1, 1'b0);
    run_phase(13'd130,   80, 150, 70, ANCHOR_LOW, 1'b1, 1'b0);
    run_phase(13'd1,     50,   6, 60, ANCHOR_LOW, 1'b1, 1'b0);
    run_phase(13'd2048,  60,  50, 60, ANCHOR_END, 1'b1, 1'b1);

    wait_idle();
    repeat (200) @(negedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
